// File: sv/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
// No dependencies.
package rrts_pkg;

    localparam int ID_W        = 4;
    localparam int SLICE_W     = 16;
    localparam int CNT_W       = 5;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_YIELD = 2'd2,
        REQ_BLOCK = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DUP_ADD   = 2'd1,
        ST_NOT_READY = 2'd2
    } t_status;

    typedef struct packed {
        t_req            req_type;
        logic [ID_W-1:0] task_id;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]  current_task;
        logic             current_valid;
        logic             switched;
        t_status          status;
        logic [CNT_W-1:0] ready_count;
    } t_result;

endpackage

// File: sv/round_robin_task_scheduler.sv
// Round-robin time-slice scheduler: circular doubly linked ready queue held in
// one RAM indexed by task (links and slice counters). Depends on rrts_pkg and rrts_ram.
// Rejected and no-op items, an add to an empty queue and a block of the last task go
// straight to S_DONE; tick and yield pass S_T1 or S_Y1, other adds the A states, other blocks the B states.
// One item in flight; start is taken again the cycle after the strobe; no output stall.
// Reset clears the queue, ready flags and slice setting (10); no clearing pass.
module round_robin_task_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  rrts_pkg::t_cmd               i_cmd,
    output logic                         o_done,
    output rrts_pkg::t_result            o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rrts_pkg::SLICE_W-1:0] i_cfg_data
);

    import rrts_pkg::*;

    localparam int NID = (MAX_TASKS < (1 << ID_W)) ? MAX_TASKS : (1 << ID_W);
    localparam int AW  = $clog2(NID);
    localparam int LW  = $clog2(NID + 1);

    typedef struct packed {
        logic [AW-1:0]      nxt;
        logic [AW-1:0]      prv;
        logic [SLICE_W-1:0] slice;
    } t_link;

    localparam int LINK_W = $bits(t_link);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_T1   = 11'b000_0000_0010,
        S_Y1   = 11'b000_0000_0100,
        S_A1   = 11'b000_0000_1000,
        S_A2   = 11'b000_0001_0000,
        S_A3   = 11'b000_0010_0000,
        S_B1   = 11'b000_0100_0000,
        S_B2   = 11'b000_1000_0000,
        S_B3   = 11'b001_0000_0000,
        S_B4   = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [LW-1:0]      r_len, n_len;
    logic [AW-1:0]      r_head, n_head;
    logic [NID-1:0]     r_ready, n_ready;
    logic [SLICE_W-1:0] r_slice_default;

    logic [AW-1:0]      r_id, n_id;
    logic [AW-1:0]      r_tail, n_tail;
    logic [AW-1:0]      r_prev, n_prev;
    logic [AW-1:0]      r_next, n_next;
    logic               r_switched, n_switched;
    t_status            r_status, n_status;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_link              ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [LINK_W-1:0]  ram_rdata;
    t_link              rd;

    logic [AW-1:0]      id_a;
    logic               id_ok;

    rrts_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NID)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd    = t_link'(ram_rdata);
    assign id_a  = i_cmd.task_id[AW-1:0];
    assign id_ok = (32'(i_cmd.task_id) < MAX_TASKS);

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_head     = r_head;
        n_ready    = r_ready;
        n_id       = r_id;
        n_tail     = r_tail;
        n_prev     = r_prev;
        n_next     = r_next;
        n_switched = r_switched;
        n_status   = r_status;
        ram_we     = 1'b0;
        ram_waddr  = r_id;
        ram_wdata  = '0;
        ram_raddr  = r_head;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_id       = id_a;
                    n_switched = 1'b0;
                    n_status   = ST_OK;
                    n_state    = S_DONE;
                    case (i_cmd.req_type)
                        REQ_ADD: begin
                            if (!id_ok) begin
                                n_state = S_DONE;
                            end else if (r_ready[id_a]) begin
                                n_status = ST_DUP_ADD;
                            end else if (r_len == '0) begin
                                ram_we         = 1'b1;
                                ram_waddr      = id_a;
                                ram_wdata      = '{nxt: id_a, prv: id_a, slice: r_slice_default};
                                n_head         = id_a;
                                n_len          = LW'(1);
                                n_ready[id_a]  = 1'b1;
                                n_switched     = 1'b1;
                            end else begin
                                n_state = S_A1;
                            end
                        end
                        REQ_TICK: begin
                            if (r_len != '0) begin
                                n_state = S_T1;
                            end
                        end
                        REQ_YIELD: begin
                            if (r_len > LW'(1)) begin
                                n_state = S_Y1;
                            end
                        end
                        REQ_BLOCK: begin
                            if (!id_ok || !r_ready[id_a]) begin
                                n_status = ST_NOT_READY;
                            end else if (r_len == LW'(1)) begin
                                n_ready[id_a] = 1'b0;
                                n_len         = '0;
                            end else begin
                                ram_raddr = id_a;
                                n_state   = S_B1;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_T1: begin
                ram_we    = 1'b1;
                ram_waddr = r_head;
                if (rd.slice[SLICE_W-1:1] == '0) begin
                    ram_wdata  = '{nxt: rd.nxt, prv: rd.prv, slice: r_slice_default};
                    n_head     = rd.nxt;
                    n_switched = (rd.nxt != r_head);
                end else begin
                    ram_wdata = '{nxt: rd.nxt, prv: rd.prv, slice: rd.slice - 1'b1};
                end
                n_state = S_DONE;
            end
            S_Y1: begin
                n_head     = rd.nxt;
                n_switched = 1'b1;
                n_state    = S_DONE;
            end
            S_A1: begin
                n_tail    = rd.prv;
                ram_we    = 1'b1;
                ram_waddr = r_head;
                ram_wdata = '{nxt: (r_len == LW'(1)) ? r_id : rd.nxt, prv: r_id,
                              slice: rd.slice};
                if (r_len == LW'(1)) begin
                    n_state = S_A3;
                end else begin
                    ram_raddr = rd.prv;
                    n_state   = S_A2;
                end
            end
            S_A2: begin
                ram_we    = 1'b1;
                ram_waddr = r_tail;
                ram_wdata = '{nxt: r_id, prv: rd.prv, slice: rd.slice};
                n_state   = S_A3;
            end
            S_A3: begin
                ram_we        = 1'b1;
                ram_waddr     = r_id;
                ram_wdata     = '{nxt: r_head, prv: r_tail, slice: r_slice_default};
                n_ready[r_id] = 1'b1;
                n_len         = r_len + 1'b1;
                n_state       = S_DONE;
            end
            S_B1: begin
                n_prev    = rd.prv;
                n_next    = rd.nxt;
                ram_raddr = rd.prv;
                n_state   = S_B2;
            end
            S_B2: begin
                ram_we    = 1'b1;
                ram_waddr = r_prev;
                ram_wdata = '{nxt: r_next, prv: (r_prev == r_next) ? r_prev : rd.prv,
                              slice: rd.slice};
                if (r_prev == r_next) begin
                    n_state = S_B4;
                end else begin
                    ram_raddr = r_next;
                    n_state   = S_B3;
                end
            end
            S_B3: begin
                ram_we    = 1'b1;
                ram_waddr = r_next;
                ram_wdata = '{nxt: rd.nxt, prv: r_prev, slice: rd.slice};
                n_state   = S_B4;
            end
            S_B4: begin
                n_ready[r_id] = 1'b0;
                n_len         = r_len - 1'b1;
                if (r_id == r_head) begin
                    n_head     = r_next;
                    n_switched = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_len           <= '0;
            r_head          <= '0;
            r_ready         <= '0;
            r_slice_default <= SLICE_RESET;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_head  <= n_head;
            r_ready <= n_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                r_slice_default <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id       <= n_id;
        r_tail     <= n_tail;
        r_prev     <= n_prev;
        r_next     <= n_next;
        r_switched <= n_switched;
        r_status   <= n_status;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = (r_state == S_DONE);

    always_comb begin
        o_result.current_valid = (r_len != '0);
        o_result.current_task  = (r_len != '0) ? ID_W'(r_head) : '0;
        o_result.switched      = r_switched;
        o_result.status        = r_status;
        o_result.ready_count   = CNT_W'(r_len);
    end

endmodule

// File: sv/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for round_robin_task_scheduler: queued commands and slice writes,
// a built-in scheduler predictor and an in-order result checker. Depends on rrts_pkg.
module tb_top;
    import rrts_pkg::*;

    localparam int CFG_SETTLE     = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 20;

    typedef enum {BL_CMD, BL_SLICE, BL_DRAIN} t_backlog_kind;

    typedef struct {
        t_backlog_kind      kind;
        t_cmd               cmd;
        logic [SLICE_W-1:0] slice;
        int                 gap_pct;
    } t_backlog_entry;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    t_cmd               i_cmd       = '0;
    logic               o_done;
    t_result            o_result;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [SLICE_W-1:0] i_cfg_data  = '0;

    t_backlog_entry     cmd_backlog[$];
    t_result            due_results[$];
    int                 sender_gap_pct;
    int                 settle_cycles;
    int                 watchdog_cycles;
    int                 errors;
    int                 cmds_sent;
    int                 results_seen;
    int                 slice_writes;
    int                 switches_seen;
    int                 peak_ready;

    // scheduler state as the block should hold it
    logic [SLICE_W-1:0] slice_setting = SLICE_RESET;
    logic [ID_W-1:0]    run_queue[$];
    logic               id_ready[16];
    logic [SLICE_W-1:0] slice_left[16];
    logic [ID_W-1:0]    run_task;
    logic               run_valid;

    round_robin_task_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic dispatch_head();
        logic [ID_W-1:0] prev_task;
        logic            prev_valid;
        prev_task  = run_task;
        prev_valid = run_valid;
        if (run_queue.size() == 0) begin
            run_valid = 1'b0;
            run_task  = '0;
            return 1'b0;
        end
        run_task  = run_queue[0];
        run_valid = 1'b1;
        return !prev_valid || prev_task != run_task;
    endfunction

    function automatic t_result predict_schedule(t_cmd c);
        t_result         r;
        logic            sw;
        t_status         st;
        int              pos;
        logic [ID_W-1:0] id;
        sw = 1'b0;
        st = ST_OK;
        id = c.task_id;
        case (c.req_type)
            REQ_ADD: begin
                if (id_ready[id]) begin
                    st = ST_DUP_ADD;
                end else if (run_queue.size() < 16) begin
                    slice_left[id] = slice_setting;
                    id_ready[id] = 1'b1;
                    run_queue.push_back(id);
                    if (!run_valid) sw = dispatch_head();
                end
            end
            REQ_TICK: begin
                if (run_valid) begin
                    if (slice_left[run_task] <= 1) begin
                        slice_left[run_task] = slice_setting;
                        run_queue.push_back(run_queue.pop_front());
                        sw = dispatch_head();
                    end else begin
                        slice_left[run_task] = slice_left[run_task] - 1'b1;
                    end
                end
            end
            REQ_YIELD: begin
                if (run_queue.size() > 1) begin
                    run_queue.push_back(run_queue.pop_front());
                    sw = dispatch_head();
                end
            end
            default: begin
                if (!id_ready[id]) begin
                    st = ST_NOT_READY;
                end else begin
                    pos = 0;
                    while (run_queue[pos] != id) pos++;
                    run_queue.delete(pos);
                    id_ready[id] = 1'b0;
                    if (pos == 0) sw = dispatch_head();
                end
            end
        endcase
        r.current_task  = run_valid ? run_task : '0;
        r.current_valid = run_valid;
        r.switched      = sw;
        r.status        = st;
        r.ready_count   = CNT_W'(run_queue.size());
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // driver: launch commands and slice writes from the backlog
    always @(posedge i_clk) begin
        logic nxt_start;
        logic nxt_cfg_valid;
        nxt_start     = start;
        nxt_cfg_valid = i_cfg_valid;
        if (!i_rst_n) begin
            nxt_start     = 1'b0;
            nxt_cfg_valid = 1'b0;
            settle_cycles = 0;
        end else begin
            if (start && !busy) begin
                due_results.push_back(predict_schedule(i_cmd));
                cmds_sent++;
                nxt_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                slice_setting = i_cfg_data;
                slice_writes++;
                nxt_cfg_valid = 1'b0;
            end
            if (!nxt_start && !nxt_cfg_valid && cmd_backlog.size() != 0) begin
                case (cmd_backlog[0].kind)
                    BL_CMD: begin
                        if ($urandom_range(99) >= cmd_backlog[0].gap_pct) begin
                            i_cmd <= cmd_backlog[0].cmd;
                            nxt_start = 1'b1;
                            cmd_backlog.delete(0);
                        end
                    end
                    BL_SLICE: begin
                        if (due_results.size() != 0) begin
                            settle_cycles = 0;
                        end else if (settle_cycles < CFG_SETTLE) begin
                            settle_cycles++;
                        end else begin
                            i_cfg_data <= cmd_backlog[0].slice;
                            nxt_cfg_valid = 1'b1;
                            settle_cycles = 0;
                            cmd_backlog.delete(0);
                        end
                    end
                    default: begin
                        if (due_results.size() == 0) cmd_backlog.delete(0);
                    end
                endcase
            end
        end
        start       <= nxt_start;
        i_cfg_valid <= nxt_cfg_valid;
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            results_seen++;
            if (o_result.switched) switches_seen++;
            if (o_result.ready_count > peak_ready) peak_ready = o_result.ready_count;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %p", $time, o_result);
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("current_task", want.current_task, o_result.current_task);
                check_field("current_valid", want.current_valid, o_result.current_valid);
                check_field("switched", want.switched, o_result.switched);
                check_field("status", want.status, o_result.status);
                check_field("ready_count", want.ready_count, o_result.ready_count);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            watchdog_cycles = 0;
        end else begin
            watchdog_cycles++;
            if (watchdog_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, watchdog_cycles, due_results.size());
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic queue_cmd(t_req r, logic [ID_W-1:0] id);
        t_backlog_entry e;
        e.kind         = BL_CMD;
        e.cmd.req_type = r;
        e.cmd.task_id  = id;
        e.slice        = '0;
        e.gap_pct      = sender_gap_pct;
        cmd_backlog.push_back(e);
    endtask

    task automatic queue_slice(logic [SLICE_W-1:0] v);
        t_backlog_entry e;
        e.kind    = BL_SLICE;
        e.cmd     = '0;
        e.slice   = v;
        e.gap_pct = 0;
        cmd_backlog.push_back(e);
    endtask

    task automatic queue_drain();
        t_backlog_entry e;
        e.kind    = BL_DRAIN;
        e.cmd     = '0;
        e.slice   = '0;
        e.gap_pct = 0;
        cmd_backlog.push_back(e);
    endtask

    // add_pct and block_pct set the mix; the rest is ticks and yields, two to one
    task automatic queue_random_burst(int n, int add_pct, int block_pct);
        int   roll;
        t_req r;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            if (roll < add_pct) r = REQ_ADD;
            else if (roll < add_pct + block_pct) r = REQ_BLOCK;
            else if ($urandom_range(2) != 0) r = REQ_TICK;
            else r = REQ_YIELD;
            queue_cmd(r, ID_W'($urandom_range(15)));
        end
    endtask

    initial begin
        int gaps[3];
        gaps = '{30, 73, 0};
        for (int t = 0; t < 16; t++) begin
            id_ready[t] = 1'b0;
            slice_left[t] = '0;
        end
        run_task  = '0;
        run_valid = 1'b0;

        sender_gap_pct = gaps[0];
        queue_cmd(REQ_TICK, 4'd3);
        queue_cmd(REQ_YIELD, 4'd0);
        queue_cmd(REQ_BLOCK, 4'd5);
        queue_cmd(REQ_ADD, 4'd0);
        queue_cmd(REQ_ADD, 4'd0);
        queue_cmd(REQ_ADD, 4'd15);
        queue_cmd(REQ_ADD, 4'd7);
        queue_cmd(REQ_YIELD, 4'd9);
        queue_cmd(REQ_TICK, 4'd0);
        queue_cmd(REQ_BLOCK, 4'd7);
        queue_cmd(REQ_BLOCK, 4'd15);
        queue_cmd(REQ_YIELD, 4'd0);
        queue_cmd(REQ_BLOCK, 4'd0);
        queue_cmd(REQ_TICK, 4'd0);
        queue_cmd(REQ_ADD, 4'd15);
        queue_cmd(REQ_BLOCK, 4'd15);
        queue_slice(16'd1);
        queue_cmd(REQ_ADD, 4'd3);
        queue_cmd(REQ_ADD, 4'd9);
        queue_cmd(REQ_TICK, 4'd0);
        queue_cmd(REQ_TICK, 4'd0);
        queue_slice(16'd0);
        queue_cmd(REQ_ADD, 4'd6);
        queue_cmd(REQ_TICK, 4'd0);
        queue_cmd(REQ_TICK, 4'd0);
        queue_cmd(REQ_TICK, 4'd0);
        queue_drain();

        for (int phase = 0; phase < 3; phase++) begin
            sender_gap_pct = gaps[phase];
            for (int seg = 0; seg < 10; seg++) begin
                if (seg == 0 && phase == 1) begin
                    queue_slice(16'hFFFF);
                end else if (seg % 3 == 0) begin
                    case ($urandom_range(4))
                        0: queue_slice(16'd1);
                        1: queue_slice(16'd0);
                        2: queue_slice(SLICE_W'($urandom_range(2, 12)));
                        3: queue_slice(SLICE_W'($urandom_range(65535)));
                        default: queue_slice(16'd2);
                    endcase
                end
                if (seg == 5) queue_drain();
                case (seg % 3)
                    0: queue_random_burst(61, 70, 10);
                    1: queue_random_burst(61, 35, 25);
                    default: queue_random_burst(61, 15, 55);
                endcase
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || start || i_cfg_valid || due_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands and %0d slice writes over three sender gap settings.",
                 cmds_sent, slice_writes);
        $display("Checked %0d results: %0d task switches, peak ready count %0d.",
                 results_seen, switches_seen, peak_ready);
        if (errors == 0 && due_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/rrts_pkg.sv
sv/rrts_ram.sv
sv/round_robin_task_scheduler.sv
verif/tb_top.sv
